/* src/ea2q_pkg.sv */
// shared types, constants and tables for the euler angle to quaternion core
package ea2q_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_W = 18;
    localparam int TRIG_W = 23;
    localparam int CORDIC_W = 34;
    localparam int ZETA_W = 33;
    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_FRAC = 20;
    localparam int TRIG_SHIFT = 30 - TRIG_FRAC;
    localparam int PAIR_W = 2 * TRIG_W;
    localparam int SPLIT = TRIG_W;
    localparam int SUM_W = 72;
    localparam int OUT_SHIFT = 3 * TRIG_FRAC - (COMPONENT_WIDTH - 1);
    localparam int SINCOS_LATENCY = CORDIC_STEPS + 2;
    localparam int TOTAL_LATENCY = SINCOS_LATENCY + 4;

    localparam logic signed [19:0] FULL_TURN = 20'sd92160;
    localparam logic signed [19:0] TWO_TURNS = 20'sd184320;
    localparam logic [16:0] QUARTER_1 = 17'd23040;
    localparam logic [16:0] QUARTER_2 = 17'd46080;
    localparam logic [16:0] QUARTER_3 = 17'd69120;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032875;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [CORDIC_W-1:0] t_xy;
    typedef logic signed [ZETA_W-1:0] t_zeta;
    typedef logic signed [COMPONENT_WIDTH-1:0] t_comp;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // arctangent of 2^-i in units of 2^-24 degree
    localparam logic signed [ZETA_W-1:0] ATAN_DEG_Q24 [CORDIC_STEPS] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
        33'sd60000934, 33'sd30029717, 33'sd15018523, 33'sd7509720,
        33'sd3754917, 33'sd1877466, 33'sd938734, 33'sd469367,
        33'sd234684, 33'sd117342, 33'sd58671, 33'sd29335,
        33'sd14668, 33'sd7334, 33'sd3667, 33'sd1833,
        33'sd917, 33'sd458, 33'sd229, 33'sd115
    };

endpackage

/* src/ea2q_sincos.sv */
// pipelined half-angle sine and cosine: range reduction, cordic stages, quadrant fold
module ea2q_sincos (
    input  logic            i_clk,
    input  ea2q_pkg::t_angle i_angle,
    output ea2q_pkg::t_trig  o_sin,
    output ea2q_pkg::t_trig  o_cos
);
    import ea2q_pkg::*;

    logic signed [19:0] a_ext;
    logic signed [19:0] red;
    logic [16:0] red_u;
    t_quad quad;
    logic [16:0] frac;

    t_xy   r_x [CORDIC_STEPS+1];
    t_xy   r_y [CORDIC_STEPS+1];
    t_zeta r_z [CORDIC_STEPS];
    t_quad r_q [CORDIC_STEPS+1];

    t_xy   y_rnd;
    t_xy   x_rnd;
    t_trig s0;
    t_trig c0;
    t_trig n_sin;
    t_trig n_cos;
    t_trig r_sin;
    t_trig r_cos;

    // reduce into one 720 degree period and split into quadrant and remainder
    always_comb begin
        a_ext = 20'(i_angle);
        if (a_ext < -FULL_TURN) begin
            red = a_ext + TWO_TURNS;
        end else if (a_ext < 0) begin
            red = a_ext + FULL_TURN;
        end else if (a_ext >= FULL_TURN) begin
            red = a_ext - FULL_TURN;
        end else begin
            red = a_ext;
        end
        red_u = red[16:0];
        if (red_u >= QUARTER_3) begin
            quad = QUAD_3;
            frac = red_u - QUARTER_3;
        end else if (red_u >= QUARTER_2) begin
            quad = QUAD_2;
            frac = red_u - QUARTER_2;
        end else if (red_u >= QUARTER_1) begin
            quad = QUAD_1;
            frac = red_u - QUARTER_1;
        end else begin
            quad = QUAD_0;
            frac = red_u;
        end
    end

    // first register stage
    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= signed'({2'b00, frac[14:0], 16'd0});
        r_q[0] <= quad;
    end

    // one rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
            end
            r_q[i+1] <= r_q[i];
        end
        if (i < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (r_z[i] >= 0) begin
                    r_z[i+1] <= r_z[i] - ATAN_DEG_Q24[i];
                end else begin
                    r_z[i+1] <= r_z[i] + ATAN_DEG_Q24[i];
                end
            end
        end
    end

    // round to signed q2.20 (23 bits) and fold by quadrant
    always_comb begin
        y_rnd = (r_y[CORDIC_STEPS] + t_xy'(1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        x_rnd = (r_x[CORDIC_STEPS] + t_xy'(1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        s0 = y_rnd[TRIG_W-1:0];
        c0 = x_rnd[TRIG_W-1:0];
        unique case (r_q[CORDIC_STEPS])
            QUAD_0: begin
                n_sin = s0;
                n_cos = c0;
            end
            QUAD_1: begin
                n_sin = c0;
                n_cos = -s0;
            end
            QUAD_2: begin
                n_sin = -s0;
                n_cos = -c0;
            end
            QUAD_3: begin
                n_sin = -c0;
                n_cos = s0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

/* src/euler_angles_to_quaternion_core.sv */
// top level: euler angles in, unit quaternion out, fully pipelined
//
// channel   direction  handshake               payload
// command   in         i_start, o_busy         i_pitch_angle, i_yaw_angle, i_roll_angle
// result    out        o_valid (one cycle)     o_quat_x, o_quat_y, o_quat_z, o_quat_w
//
// one beat is taken every cycle; o_busy is always low
// the path runs through range reduction, 24 cordic stages, quadrant fold,
// then four stages of products, split partial products, sums and rounding
// synchronous reset clears only the valid pipeline; data registers flow freely
// the receiver cannot stall, so nothing is ever held back
module euler_angles_to_quaternion_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ea2q_pkg::t_angle  i_pitch_angle,
    input  ea2q_pkg::t_angle  i_yaw_angle,
    input  ea2q_pkg::t_angle  i_roll_angle,
    output logic              o_valid,
    output ea2q_pkg::t_comp   o_quat_x,
    output ea2q_pkg::t_comp   o_quat_y,
    output ea2q_pkg::t_comp   o_quat_z,
    output ea2q_pkg::t_comp   o_quat_w
);
    import ea2q_pkg::*;

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((64'sd1 <<< (COMPONENT_WIDTH - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

    t_trig sp, cp, sy, cy, sr, cr;

    logic [TOTAL_LATENCY-1:0] r_valid;

    logic signed [PAIR_W-1:0] r_pcc, r_pss, r_psc, r_pcs;
    t_trig r_sr_a, r_cr_a;

    logic signed [PAIR_W-1:0] pair_of [8];
    t_trig fac_of [8];
    logic signed [PAIR_W-1:0] r_hi [8];
    logic signed [PAIR_W:0]   r_lo [8];

    logic signed [PAIR_W:0]   r_shi [4];
    logic signed [PAIR_W+1:0] r_slo [4];

    logic signed [SUM_W-1:0] tot [4];
    logic signed [SUM_W-1:0] shf [4];
    t_comp n_q [4];
    t_comp r_q [4];

    ea2q_sincos u_pitch (.i_clk(i_clk), .i_angle(i_pitch_angle), .o_sin(sp), .o_cos(cp));
    ea2q_sincos u_yaw   (.i_clk(i_clk), .i_angle(i_yaw_angle),   .o_sin(sy), .o_cos(cy));
    ea2q_sincos u_roll  (.i_clk(i_clk), .i_angle(i_roll_angle),  .o_sin(sr), .o_cos(cr));

    // valid bits follow the data through every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[TOTAL_LATENCY-2:0], i_start};
        end
    end

    // pitch by yaw products
    always_ff @(posedge i_clk) begin
        r_pcc  <= cp * cy;
        r_pss  <= sp * sy;
        r_psc  <= sp * cy;
        r_pcs  <= cp * sy;
        r_sr_a <= sr;
        r_cr_a <= cr;
    end

    // term order: x = t0 - t1, y = t2 + t3, z = t4 - t5, w = t6 + t7
    always_comb begin
        pair_of[0] = r_pcc;  fac_of[0] = r_sr_a;
        pair_of[1] = r_pss;  fac_of[1] = r_cr_a;
        pair_of[2] = r_psc;  fac_of[2] = r_cr_a;
        pair_of[3] = r_pcs;  fac_of[3] = r_sr_a;
        pair_of[4] = r_pcs;  fac_of[4] = r_cr_a;
        pair_of[5] = r_psc;  fac_of[5] = r_sr_a;
        pair_of[6] = r_pcc;  fac_of[6] = r_cr_a;
        pair_of[7] = r_pss;  fac_of[7] = r_sr_a;
    end

    // roll factor times high and low halves of each pair
    for (genvar k = 0; k < 8; k++) begin : g_term
        always_ff @(posedge i_clk) begin
            r_hi[k] <= fac_of[k] * signed'(pair_of[k][PAIR_W-1:SPLIT]);
            r_lo[k] <= (PAIR_W+1)'(fac_of[k] * signed'({1'b0, pair_of[k][SPLIT-1:0]}));
        end
    end

    // combine the two terms of each component, halves kept apart
    always_ff @(posedge i_clk) begin
        r_shi[0] <= (PAIR_W+1)'(r_hi[0]) - (PAIR_W+1)'(r_hi[1]);
        r_shi[1] <= (PAIR_W+1)'(r_hi[2]) + (PAIR_W+1)'(r_hi[3]);
        r_shi[2] <= (PAIR_W+1)'(r_hi[4]) - (PAIR_W+1)'(r_hi[5]);
        r_shi[3] <= (PAIR_W+1)'(r_hi[6]) + (PAIR_W+1)'(r_hi[7]);
        r_slo[0] <= (PAIR_W+2)'(r_lo[0]) - (PAIR_W+2)'(r_lo[1]);
        r_slo[1] <= (PAIR_W+2)'(r_lo[2]) + (PAIR_W+2)'(r_lo[3]);
        r_slo[2] <= (PAIR_W+2)'(r_lo[4]) - (PAIR_W+2)'(r_lo[5]);
        r_slo[3] <= (PAIR_W+2)'(r_lo[6]) + (PAIR_W+2)'(r_lo[7]);
    end

    // merge halves, round and saturate
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            tot[c] = (SUM_W'(r_shi[c]) <<< SPLIT) + SUM_W'(r_slo[c]) + HALF;
            shf[c] = tot[c] >>> OUT_SHIFT;
            if (shf[c] > MAXV) begin
                n_q[c] = MAXV[COMPONENT_WIDTH-1:0];
            end else if (shf[c] < MINV) begin
                n_q[c] = MINV[COMPONENT_WIDTH-1:0];
            end else begin
                n_q[c] = shf[c][COMPONENT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_q[c] <= n_q[c];
        end
    end

    assign o_busy   = 1'b0;
    assign o_valid  = r_valid[TOTAL_LATENCY-1];
    assign o_quat_x = r_q[0];
    assign o_quat_y = r_q[1];
    assign o_quat_z = r_q[2];
    assign o_quat_w = r_q[3];

endmodule
